// ===== rtl/core/two_channel_lux_calculator_top_defines.svh =====
// Assertion macros shared by the lux calculator modules.
`ifndef TWO_CHANNEL_LUX_CALCULATOR_TOP_DEFINES_SVH
`define TWO_CHANNEL_LUX_CALCULATOR_TOP_DEFINES_SVH

// The property must hold in the same cycle as its trigger.
`define TLC_ASSERT_SAME(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after its trigger.
`define TLC_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/tlc_pkg.sv =====
package tlc_pkg;

    localparam int unsigned POWER_TABLE_DEPTH = 64;
    localparam int unsigned RATIO_FRAC_BITS   = 10;

    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned LUX_W         = 19;
    localparam int unsigned LUX_FRAC_BITS = 8;
    localparam logic [LUX_W-1:0] LUX_MAX  = '1;

    localparam int unsigned IDX_W = $clog2(POWER_TABLE_DEPTH + 1);

    // The table depth is a power of two, so the table grid divides by shifts.
    localparam int unsigned DEPTH_LOG2 = $clog2(POWER_TABLE_DEPTH);

    // The coefficient scale of 100000 splits into a power of two and an odd part.
    localparam int unsigned COEF_SCALE_POW2 = 5;
    localparam int unsigned COEF_SCALE_ODD  = 3125;

    localparam longint unsigned LOW_BASE  = 64'd3040 << 16;
    localparam longint unsigned LOW_SLOPE = 64'd6200;
    localparam int unsigned COEF_W = $clog2(LOW_BASE + 1);

    localparam int unsigned LIN_COEF_W = 12;
    localparam int unsigned LIN_W      = COUNT_W + LIN_COEF_W;
    localparam logic [LIN_COEF_W-1:0] MID_A  = 12'd2240;
    localparam logic [LIN_COEF_W-1:0] MID_B  = 12'd3100;
    localparam logic [LIN_COEF_W-1:0] HIGH_A = 12'd1280;
    localparam logic [LIN_COEF_W-1:0] HIGH_B = 12'd1530;
    localparam logic [LIN_COEF_W-1:0] IR_A   = 12'd146;
    localparam logic [LIN_COEF_W-1:0] IR_B   = 12'd112;

    localparam int unsigned LOW_SHIFT = COEF_SCALE_POW2 + LUX_FRAC_BITS;
    localparam int unsigned LIN_SHIFT = LUX_FRAC_BITS - COEF_SCALE_POW2;
    localparam int unsigned X_W       = COUNT_W + COEF_W - LOW_SHIFT;

    localparam int unsigned RECIP_SHIFT = X_W;
    localparam longint unsigned RECIP_MUL = (64'd1 << RECIP_SHIFT) / COEF_SCALE_ODD;
    localparam int unsigned RECIP_W = $clog2(RECIP_MUL + 1);
    localparam int unsigned QUOT_W  = X_W - $clog2(COEF_SCALE_ODD) + 1;

    localparam int unsigned DIV_STEPS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES =
        (RATIO_FRAC_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    typedef enum logic [2:0] {
        SEG_ZERO = 3'd0,
        SEG_LOW  = 3'd1,
        SEG_MID  = 3'd2,
        SEG_HIGH = 3'd3,
        SEG_IR   = 3'd4,
        SEG_OVER = 3'd5
    } t_segment;

    typedef struct packed {
        logic [COUNT_W-1:0] ch0;
        logic [COUNT_W-1:0] ch1;
        t_segment           seg;
    } t_sample;

    typedef struct packed {
        t_sample                    sample;
        logic [RATIO_FRAC_BITS-1:0] ratio;
    } t_ratio_word;

    typedef logic [COEF_W-1:0] t_coef_rom [POWER_TABLE_DEPTH + 1];

    // x^1.4 with 16 fractional bits, where x = idx / (2 * depth).
    function automatic longint unsigned power_entry(input longint unsigned idx);
        longint unsigned i;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        i = (idx > POWER_TABLE_DEPTH) ? POWER_TABLE_DEPTH : idx;
        s = ((i * i) << 40) >> (2 * DEPTH_LOG2 + 2);
        s = s << 20;
        lo = 0;
        hi = 4096;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p = mid * mid * mid * mid * mid;
            if (p <= s) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (i * lo * 16) >> (DEPTH_LOG2 + 1);
    endfunction

    // The low segment coefficient 3040 * 2^16 - 6200 * x^1.4 for every table point.
    function automatic t_coef_rom build_coef_rom();
        t_coef_rom rom;
        for (int i = 0; i <= POWER_TABLE_DEPTH; i++) begin
            rom[i] = COEF_W'(LOW_BASE - LOW_SLOPE * power_entry(longint'(i)));
        end
        return rom;
    endfunction

    localparam t_coef_rom LOW_COEF_ROM = build_coef_rom();

endpackage

// ===== rtl/core/tlc_if.sv =====
interface tlc_in_if;
    logic                         valid;
    logic                         ready;
    logic [tlc_pkg::COUNT_W-1:0]  broadband_count;
    logic [tlc_pkg::COUNT_W-1:0]  infrared_count;

    modport source (output valid, output broadband_count, output infrared_count,
                    input ready);
    modport sink   (input valid, input broadband_count, input infrared_count,
                    output ready);
endinterface

interface tlc_out_if;
    logic                       valid;
    logic                       ready;
    logic [tlc_pkg::LUX_W-1:0]  lux_fixed;
    logic [2:0]                 segment;

    modport source (output valid, output lux_fixed, output segment, input ready);
    modport sink   (input valid, input lux_fixed, input segment, output ready);
endinterface

// ===== rtl/core/tlc_segment.sv =====
module tlc_segment (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tlc_in_if.sink           i_in,
    output logic             o_valid,
    input  logic             i_ready,
    output tlc_pkg::t_sample o_sample
);

    localparam int unsigned CMP_W = tlc_pkg::COUNT_W + 7;

    logic             r_valid;
    tlc_pkg::t_sample r_sample;
    tlc_pkg::t_sample n_sample;
    logic             w_en;
    logic [CMP_W-1:0] w_ch0;
    logic [CMP_W-1:0] w_ch1;

    assign w_en       = !r_valid || i_ready;
    assign i_in.ready = w_en;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;

    // The ratio bounds are tested by cross multiplication, so the choice is exact.
    always_comb begin
        w_ch0 = CMP_W'(i_in.broadband_count);
        w_ch1 = CMP_W'(i_in.infrared_count);
        n_sample.ch0 = i_in.broadband_count;
        n_sample.ch1 = i_in.infrared_count;
        priority if (w_ch0 == '0) begin
            n_sample.seg = tlc_pkg::SEG_ZERO;
        end else if (w_ch1 * CMP_W'(2) <= w_ch0) begin
            n_sample.seg = tlc_pkg::SEG_LOW;
        end else if (w_ch1 * CMP_W'(100) <= w_ch0 * CMP_W'(61)) begin
            n_sample.seg = tlc_pkg::SEG_MID;
        end else if (w_ch1 * CMP_W'(10) <= w_ch0 * CMP_W'(8)) begin
            n_sample.seg = tlc_pkg::SEG_HIGH;
        end else if (w_ch1 * CMP_W'(10) <= w_ch0 * CMP_W'(13)) begin
            n_sample.seg = tlc_pkg::SEG_IR;
        end else begin
            n_sample.seg = tlc_pkg::SEG_OVER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_in.valid) begin
            r_sample <= n_sample;
        end
    end

endmodule

// ===== rtl/core/tlc_ratio_div.sv =====
`include "two_channel_lux_calculator_top_defines.svh"

module tlc_ratio_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tlc_pkg::t_sample     i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tlc_pkg::t_ratio_word o_word
);

    localparam int unsigned F      = tlc_pkg::RATIO_FRAC_BITS;
    localparam int unsigned STEPS  = tlc_pkg::DIV_STEPS_PER_STAGE;
    localparam int unsigned STAGES = tlc_pkg::DIV_STAGES;
    localparam int unsigned CW     = tlc_pkg::COUNT_W;

    typedef struct packed {
        tlc_pkg::t_sample sample;
        logic [CW-1:0]    rem;
        logic [F-1:0]     quo;
    } t_div_slot;

    t_div_slot         r_slot [STAGES];
    t_div_slot         n_slot [STAGES];
    t_div_slot         w_src  [STAGES];
    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] w_src_valid;
    logic [STAGES:0]   w_chain;

    assign w_src_valid = {r_valid[STAGES-2:0], i_valid};
    assign o_ready     = w_chain[0];
    assign o_valid     = r_valid[STAGES-1];
    assign o_word.sample = r_slot[STAGES-1].sample;
    assign o_word.ratio  = r_slot[STAGES-1].quo;

    always_comb begin
        w_chain[STAGES] = i_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_chain[k] = !r_valid[k] || w_chain[k + 1];
        end
    end

    // Only the low segment needs the ratio; other words divide zero.
    always_comb begin
        w_src[0].sample = i_sample;
        w_src[0].rem    = (i_sample.seg == tlc_pkg::SEG_LOW) ? i_sample.ch1 : '0;
        w_src[0].quo    = '0;
        for (int k = 1; k < STAGES; k++) begin
            w_src[k] = r_slot[k - 1];
        end
    end

    // Restoring division, two quotient bits per stage.
    always_comb begin
        logic [CW:0] trial;
        t_div_slot   slot;
        trial = '0;
        for (int k = 0; k < STAGES; k++) begin
            slot = w_src[k];
            for (int j = 0; j < STEPS; j++) begin
                if (k * STEPS + j < F) begin
                    trial = {slot.rem, 1'b0};
                    if (slot.sample.seg == tlc_pkg::SEG_LOW &&
                        trial >= {1'b0, slot.sample.ch0}) begin
                        slot.rem = CW'(trial - {1'b0, slot.sample.ch0});
                        slot.quo = {slot.quo[F-2:0], 1'b1};
                    end else begin
                        slot.rem = trial[CW-1:0];
                        slot.quo = {slot.quo[F-2:0], 1'b0};
                    end
                end
            end
            n_slot[k] = slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_chain[k]) begin
                    r_valid[k] <= w_src_valid[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (w_chain[k] && w_src_valid[k]) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    `TLC_ASSERT_SAME(a_low_ratio_range, i_clk, i_rst_n,
        r_valid[STAGES-1] && r_slot[STAGES-1].sample.seg == tlc_pkg::SEG_LOW,
        r_slot[STAGES-1].quo <= F'(1 << (F - 1)) &&
        r_slot[STAGES-1].rem < r_slot[STAGES-1].sample.ch0,
        "ratio of a low segment word is out of range")
    `TLC_ASSERT_SAME(a_other_ratio_zero, i_clk, i_rst_n,
        r_valid[STAGES-1] && r_slot[STAGES-1].sample.seg != tlc_pkg::SEG_LOW,
        r_slot[STAGES-1].quo == '0,
        "ratio of a word outside the low segment is not zero")
    `TLC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        r_valid[STAGES-1] && !i_ready,
        r_valid[STAGES-1] && $stable(o_word),
        "stalled divider word changed")

endmodule

// ===== rtl/core/tlc_lux_scale.sv =====
`include "two_channel_lux_calculator_top_defines.svh"

module tlc_lux_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tlc_pkg::t_ratio_word i_word,
    tlc_out_if.source            o_out
);

    localparam int unsigned F      = tlc_pkg::RATIO_FRAC_BITS;
    localparam int unsigned D      = tlc_pkg::POWER_TABLE_DEPTH;
    localparam int unsigned TWO_D  = 2 * D;
    localparam int unsigned SUM_W  = F + $clog2(TWO_D) + 1;
    localparam int unsigned RAW_W  = SUM_W - F;
    localparam int unsigned IW     = tlc_pkg::IDX_W;
    localparam int unsigned CW     = tlc_pkg::COUNT_W;
    localparam int unsigned KW     = tlc_pkg::COEF_W;
    localparam int unsigned LW     = tlc_pkg::LIN_W;
    localparam int unsigned PW     = CW + KW;
    localparam int unsigned XW     = tlc_pkg::X_W;
    localparam int unsigned MW     = XW + tlc_pkg::RECIP_W;
    localparam int unsigned QW     = tlc_pkg::QUOT_W;
    localparam int unsigned BW     = XW + 2;
    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] w_src_valid;
    logic [STAGES:0]   w_chain;

    logic [IW-1:0]     r_s0_idx;
    logic [LW-1:0]     r_s0_pa;
    logic [LW-1:0]     r_s0_pb;
    logic [CW-1:0]     r_s0_ch0;
    tlc_pkg::t_segment r_s0_seg;

    logic [KW-1:0]     r_s1_coef;
    logic [LW-1:0]     r_s1_lin;
    logic [CW-1:0]     r_s1_ch0;
    tlc_pkg::t_segment r_s1_seg;

    logic [PW-1:0]     r_s2_prod;
    logic [LW-1:0]     r_s2_lin;
    tlc_pkg::t_segment r_s2_seg;

    logic [XW-1:0]     r_s3_x;
    logic [QW-1:0]     r_s3_qest;
    tlc_pkg::t_segment r_s3_seg;

    logic [tlc_pkg::LUX_W-1:0] r_out_lux;
    tlc_pkg::t_segment         r_out_seg;

    logic [SUM_W-1:0]            w_sum;
    logic [RAW_W-1:0]            w_idx_raw;
    logic [IW-1:0]               n_s0_idx;
    logic [tlc_pkg::LIN_COEF_W-1:0] w_coef_a;
    logic [tlc_pkg::LIN_COEF_W-1:0] w_coef_b;
    logic [LW:0]                 w_diff;
    logic [LW-1:0]               n_s1_lin;
    logic [XW-1:0]               n_s3_x;
    logic [MW-1:0]               w_recip;
    logic [BW-1:0]               w_bound;
    logic [QW-1:0]               w_quot;
    logic [tlc_pkg::LUX_W-1:0]   n_out_lux;

    assign w_src_valid = {r_valid[STAGES-2:0], i_valid};
    assign o_ready     = w_chain[0];

    always_comb begin
        w_chain[STAGES] = o_out.ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_chain[k] = !r_valid[k] || w_chain[k + 1];
        end
    end

    // Table index: the ratio rounded onto the table grid, clamped at its top entry.
    always_comb begin
        w_sum     = SUM_W'(i_word.ratio) * SUM_W'(TWO_D) + SUM_W'(1 << (F - 1));
        w_idx_raw = w_sum[SUM_W-1:F];
        if (w_idx_raw > RAW_W'(D)) begin
            n_s0_idx = IW'(D);
        end else begin
            n_s0_idx = w_idx_raw[IW-1:0];
        end
        unique case (i_word.sample.seg)
            tlc_pkg::SEG_MID: begin
                w_coef_a = tlc_pkg::MID_A;
                w_coef_b = tlc_pkg::MID_B;
            end
            tlc_pkg::SEG_HIGH: begin
                w_coef_a = tlc_pkg::HIGH_A;
                w_coef_b = tlc_pkg::HIGH_B;
            end
            tlc_pkg::SEG_IR: begin
                w_coef_a = tlc_pkg::IR_A;
                w_coef_b = tlc_pkg::IR_B;
            end
            default: begin
                w_coef_a = '0;
                w_coef_b = '0;
            end
        endcase
    end

    always_comb begin
        w_diff   = {1'b0, r_s0_pa} - {1'b0, r_s0_pb};
        n_s1_lin = w_diff[LW] ? '0 : w_diff[LW-1:0];
    end

    // Both formulas meet in one divide by the odd part of the scale.
    always_comb begin
        if (r_s2_seg == tlc_pkg::SEG_LOW) begin
            n_s3_x = r_s2_prod[tlc_pkg::LOW_SHIFT +: XW];
        end else begin
            n_s3_x = XW'(r_s2_lin) << tlc_pkg::LIN_SHIFT;
        end
        w_recip = MW'(n_s3_x) * MW'(tlc_pkg::RECIP_MUL);
    end

    // The reciprocal estimate is low by at most one.
    always_comb begin
        w_bound = BW'(r_s3_qest) * BW'(tlc_pkg::COEF_SCALE_ODD)
                + BW'(tlc_pkg::COEF_SCALE_ODD);
        w_quot  = r_s3_qest + QW'(BW'(r_s3_x) >= w_bound);
        if (r_s3_seg == tlc_pkg::SEG_ZERO || r_s3_seg == tlc_pkg::SEG_OVER) begin
            n_out_lux = '0;
        end else if (w_quot > QW'(tlc_pkg::LUX_MAX)) begin
            n_out_lux = tlc_pkg::LUX_MAX;
        end else begin
            n_out_lux = w_quot[tlc_pkg::LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_chain[k]) begin
                    r_valid[k] <= w_src_valid[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chain[0] && w_src_valid[0]) begin
            r_s0_idx <= n_s0_idx;
            r_s0_pa  <= LW'(i_word.sample.ch0) * LW'(w_coef_a);
            r_s0_pb  <= LW'(i_word.sample.ch1) * LW'(w_coef_b);
            r_s0_ch0 <= i_word.sample.ch0;
            r_s0_seg <= i_word.sample.seg;
        end
        if (w_chain[1] && w_src_valid[1]) begin
            r_s1_coef <= tlc_pkg::LOW_COEF_ROM[r_s0_idx];
            r_s1_lin  <= n_s1_lin;
            r_s1_ch0  <= r_s0_ch0;
            r_s1_seg  <= r_s0_seg;
        end
        if (w_chain[2] && w_src_valid[2]) begin
            r_s2_prod <= PW'(r_s1_ch0) * PW'(r_s1_coef);
            r_s2_lin  <= r_s1_lin;
            r_s2_seg  <= r_s1_seg;
        end
        if (w_chain[3] && w_src_valid[3]) begin
            r_s3_x    <= n_s3_x;
            r_s3_qest <= w_recip[tlc_pkg::RECIP_SHIFT +: QW];
            r_s3_seg  <= r_s2_seg;
        end
        if (w_chain[4] && w_src_valid[4]) begin
            r_out_lux <= n_out_lux;
            r_out_seg <= r_s3_seg;
        end
    end

    assign o_out.valid     = r_valid[STAGES-1];
    assign o_out.lux_fixed = r_out_lux;
    assign o_out.segment   = r_out_seg;

    `TLC_ASSERT_SAME(a_recip_bound, i_clk, i_rst_n,
        r_valid[3],
        BW'(r_s3_x) >= BW'(r_s3_qest) * BW'(tlc_pkg::COEF_SCALE_ODD) &&
        BW'(r_s3_x) < BW'(r_s3_qest) * BW'(tlc_pkg::COEF_SCALE_ODD)
                      + BW'(2 * tlc_pkg::COEF_SCALE_ODD),
        "reciprocal quotient estimate is off by more than one")
    `TLC_ASSERT_SAME(a_no_light_zero, i_clk, i_rst_n,
        r_valid[STAGES-1] &&
        (r_out_seg == tlc_pkg::SEG_ZERO || r_out_seg == tlc_pkg::SEG_OVER),
        r_out_lux == '0,
        "lux is not zero for an empty or out of range word")

endmodule

// ===== rtl/core/two_channel_lux_calculator_top.sv =====
// Lux calculator: each word on i_in carries a broadband and an infrared count and
// yields one word on o_out with lux (8 fractional bits) and the segment that was used.
// A new word is taken every cycle unless backpressure on o_out stalls the pipeline;
// each word passes the classify stage, the divider that forms two ratio bits per
// stage, and the five stages of table lookup, multiplication and scaling. Each stage
// holds its word under backpressure, so bubbles in the pipeline are still filled
// while the output waits.
module two_channel_lux_calculator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlc_in_if.sink    i_in,
    tlc_out_if.source o_out
);

    logic                 w_seg_valid;
    logic                 w_seg_ready;
    tlc_pkg::t_sample     w_seg_sample;
    logic                 w_div_valid;
    logic                 w_div_ready;
    tlc_pkg::t_ratio_word w_div_word;

    tlc_segment u_segment (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_valid  (w_seg_valid),
        .i_ready  (w_seg_ready),
        .o_sample (w_seg_sample)
    );

    tlc_ratio_div u_ratio_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_seg_valid),
        .o_ready  (w_seg_ready),
        .i_sample (w_seg_sample),
        .o_valid  (w_div_valid),
        .i_ready  (w_div_ready),
        .o_word   (w_div_word)
    );

    tlc_lux_scale u_lux_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_word  (w_div_word),
        .o_out   (o_out)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY      = 1 + tlc_pkg::DIV_STAGES + 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 450;
    localparam int NUM_DIRECTED = 24;

    // Each entry packs {broadband_count, infrared_count}.
    localparam logic [31:0] DIRECTED [NUM_DIRECTED] = '{
        {16'd0,     16'd0},     {16'd0,     16'd65535}, {16'd1,     16'd0},
        {16'd65535, 16'd0},     {16'd65535, 16'd65535}, {16'd1,     16'd1},
        {16'd2,     16'd1},     {16'd65535, 16'd32767}, {16'd65535, 16'd32768},
        {16'd32768, 16'd16384}, {16'd100,   16'd61},    {16'd100,   16'd62},
        {16'd10,    16'd8},     {16'd10,    16'd9},     {16'd10,    16'd13},
        {16'd10,    16'd14},    {16'd1,     16'd2},     {16'd50000, 16'd65000},
        {16'd50000, 16'd65001}, {16'h5555,  16'hAAAA},  {16'hAAAA,  16'h5555},
        {16'hFFFF,  16'd1},     {16'd3,     16'd1},     {16'd40000, 16'd24400}
    };

    localparam int BOUNDARY_PERMILLE [4] = '{500, 610, 800, 1300};

    typedef struct {
        logic [tlc_pkg::LUX_W-1:0] lux;
        tlc_pkg::t_segment         seg;
    } t_lux_reading;

    class t_lux_scoreboard;
        t_lux_reading    expected_q[$];
        int unsigned     mismatches;
        longint unsigned pow_table [tlc_pkg::POWER_TABLE_DEPTH + 1];

        function new();
            longint unsigned sq;
            longint unsigned s;
            longint unsigned q;
            longint unsigned t;
            mismatches = 0;
            // The table holds x^1.4 with 16 fractional bits, x = i / (2 * depth),
            // built from the fifth root of x^2 found bit by bit.
            for (int i = 0; i <= tlc_pkg::POWER_TABLE_DEPTH; i++) begin
                sq = longint'(i) * longint'(i);
                s = ((sq << 40) / (64'd4 * tlc_pkg::POWER_TABLE_DEPTH
                                   * tlc_pkg::POWER_TABLE_DEPTH)) << 20;
                q = 0;
                for (int b = 12; b >= 0; b--) begin
                    t = q | (64'd1 << b);
                    if (t <= 4096 && t * t * t * t * t <= s) begin
                        q = t;
                    end
                end
                pow_table[i] = (longint'(i) * q * 16) / (64'd2 * tlc_pkg::POWER_TABLE_DEPTH);
            end
        endfunction

        function logic [tlc_pkg::LUX_W-1:0] saturate(longint v);
            if (v < 0) begin
                return '0;
            end
            if (v > longint'(tlc_pkg::LUX_MAX)) begin
                return tlc_pkg::LUX_MAX;
            end
            return v[tlc_pkg::LUX_W-1:0];
        endfunction

        function t_lux_reading predict_reading(logic [tlc_pkg::COUNT_W-1:0] ch0,
                                               logic [tlc_pkg::COUNT_W-1:0] ch1);
            t_lux_reading r;
            longint c0;
            longint c1;
            longint ratio;
            longint idx;
            longint num;
            longint a;
            longint b;
            c0 = longint'(ch0);
            c1 = longint'(ch1);
            r.lux = '0;
            a = 0;
            b = 0;
            if (c0 == 0) begin
                r.seg = tlc_pkg::SEG_ZERO;
            end else if (2 * c1 <= c0) begin
                ratio = (c1 << tlc_pkg::RATIO_FRAC_BITS) / c0;
                idx = (ratio * 2 * longint'(tlc_pkg::POWER_TABLE_DEPTH)
                       + (longint'(1) << (tlc_pkg::RATIO_FRAC_BITS - 1)))
                      >> tlc_pkg::RATIO_FRAC_BITS;
                if (idx > longint'(tlc_pkg::POWER_TABLE_DEPTH)) begin
                    idx = tlc_pkg::POWER_TABLE_DEPTH;
                end
                num = c0 * (longint'(3040) * 65536 - longint'(6200) * longint'(pow_table[idx]));
                r.seg = tlc_pkg::SEG_LOW;
                r.lux = saturate(num / (longint'(100000) * 256));
            end else begin
                if (100 * c1 <= 61 * c0) begin
                    r.seg = tlc_pkg::SEG_MID;
                    a = 2240;
                    b = 3100;
                end else if (10 * c1 <= 8 * c0) begin
                    r.seg = tlc_pkg::SEG_HIGH;
                    a = 1280;
                    b = 1530;
                end else if (10 * c1 <= 13 * c0) begin
                    r.seg = tlc_pkg::SEG_IR;
                    a = 146;
                    b = 112;
                end else begin
                    r.seg = tlc_pkg::SEG_OVER;
                end
                num = (a * c0 - b * c1) * 256;
                if (r.seg != tlc_pkg::SEG_OVER) begin
                    r.lux = saturate(num / 100000);
                end
            end
            return r;
        endfunction

        function void note_sample(logic [tlc_pkg::COUNT_W-1:0] ch0,
                                  logic [tlc_pkg::COUNT_W-1:0] ch1);
            expected_q.push_back(predict_reading(ch0, ch1));
        endfunction

        function void check_reading(logic [tlc_pkg::LUX_W-1:0] lux, logic [2:0] seg);
            t_lux_reading want;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation waiting: lux_fixed %0d, segment %0d",
                       lux, seg);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (lux !== want.lux) begin
                $error("lux_fixed: expected %0d, actual %0d", want.lux, lux);
                mismatches++;
            end
            if (seg !== want.seg) begin
                $error("segment: expected %0d, actual %0d", want.seg, seg);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   stall_cycles = 0;
    logic [15:0] rx_cycle = '0;

    t_lux_scoreboard sb = new();

    tlc_in_if  in_word();
    tlc_out_if out_word();

    two_channel_lux_calculator_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_word),
        .o_out   (out_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_word.valid && in_word.ready) begin
                sb.note_sample(in_word.broadband_count, in_word.infrared_count);
            end
            if (out_word.valid && out_word.ready) begin
                sb.check_reading(out_word.lux_fixed, out_word.segment);
            end
        end
    end

    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (!rst_n) begin
            out_word.ready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0: out_word.ready <= 1'b1;
                2'd1: out_word.ready <= ($urandom_range(0, 1) == 0);
                2'd2: out_word.ready <= (rx_cycle[1:0] == 2'd0);
                default: out_word.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [tlc_pkg::COUNT_W-1:0] ch0,
                             input logic [tlc_pkg::COUNT_W-1:0] ch1);
        in_word.valid           <= 1'b1;
        in_word.broadband_count <= ch0;
        in_word.infrared_count  <= ch1;
        do @(posedge clk); while (!in_word.ready);
    endtask

    task automatic idle_sender(input int cycles);
        in_word.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        in_word.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic pick_random_pair(output logic [tlc_pkg::COUNT_W-1:0] ch0,
                                    output logic [tlc_pkg::COUNT_W-1:0] ch1);
        int unsigned     mode;
        longint unsigned base;
        longint unsigned other;
        base = longint'($urandom_range(1, 65535)) >> $urandom_range(0, 15);
        if (base == 0) begin
            base = 1;
        end
        other = 0;
        mode = $urandom_range(0, 9);
        if (mode <= 1) begin
            base = $urandom_range(0, 65535);
            other = $urandom_range(0, 65535);
        end else if (mode == 2) begin
            base = 0;
            other = $urandom_range(0, 65535) >> $urandom_range(0, 15);
        end else if (mode <= 6) begin
            other = base * $urandom_range(0, 1500) / 1000;
        end else if (mode <= 8) begin
            other = base * BOUNDARY_PERMILLE[$urandom_range(0, 3)] / 1000
                    + $urandom_range(0, 2);
            other = (other == 0) ? 0 : other - 1;
        end else begin
            base = $urandom_range(0, 15);
            other = $urandom_range(0, 15);
        end
        ch0 = base[tlc_pkg::COUNT_W-1:0];
        ch1 = (other > 65535) ? 16'hFFFF : other[tlc_pkg::COUNT_W-1:0];
    endtask

    initial begin
        int   sent;
        int   burst;
        bit   paused_mid;
        logic [tlc_pkg::COUNT_W-1:0] ch0;
        logic [tlc_pkg::COUNT_W-1:0] ch1;
        sent = 0;
        paused_mid = 1'b0;
        rst_n                   <= 1'b0;
        in_word.valid           <= 1'b0;
        in_word.broadband_count <= '0;
        in_word.infrared_count  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_word(DIRECTED[i][31:16], DIRECTED[i][15:0]);
        end
        drain_results();

        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                pick_random_pair(ch0, ch1);
                send_word(ch0, ch1);
                sent++;
            end
            if (!paused_mid && sent >= 300) begin
                paused_mid = 1'b1;
                drain_results();
            end else if (sent < 150 || sent > 260) begin
                if ($urandom_range(0, 2) != 0) begin
                    idle_sender($urandom_range(1, 12));
                end
            end
        end

        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
